/* design/tdes_pkg.sv */
// Package for the Triple DES core: DES permutation tables, S-boxes and helper
// functions for the permutations, the Feistel function and the key schedule.
// No dependencies.
package tdes_pkg;

  localparam int NumRounds = 16;
  localparam int NumPasses = 3;
  localparam int NumStages = NumRounds * NumPasses;

  // Configuration register indexes.
  localparam logic [1:0] RegKeyOne   = 2'd0;
  localparam logic [1:0] RegKeyTwo   = 2'd1;
  localparam logic [1:0] RegKeyThree = 2'd2;
  localparam logic [1:0] RegDir      = 2'd3;

  typedef logic [47:0] subkey_t;
  typedef logic [55:0] cd_t;

  typedef logic [6:0] tidx64_t [64];

  localparam tidx64_t TblIp = '{
    7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2, 7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
    7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6, 7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1, 7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
    7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5, 7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

  localparam tidx64_t TblFp = '{
    7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32, 7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
    7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30, 7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
    7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28, 7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
    7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26, 7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

  localparam logic [5:0] TblE [48] = '{
    6'd32,6'd1,6'd2,6'd3,6'd4,6'd5, 6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
    6'd8,6'd9,6'd10,6'd11,6'd12,6'd13, 6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
    6'd16,6'd17,6'd18,6'd19,6'd20,6'd21, 6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
    6'd24,6'd25,6'd26,6'd27,6'd28,6'd29, 6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};

  localparam logic [5:0] TblP [32] = '{
    6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17, 6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
    6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9, 6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};

  localparam logic [6:0] TblPc1 [56] = '{
    7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
    7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
    7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
    7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

  localparam logic [5:0] TblPc2 [48] = '{
    6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
    6'd23,6'd19,6'd12,6'd4,6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
    6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
    6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

  // Left rotation amount per round.
  localparam logic [1:0] TblRot [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

  localparam logic [3:0] TblS [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // Table positions count from 1 at the most significant bit.
  function automatic logic [63:0] perm64(input logic [63:0] src, input tidx64_t t);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = src[64 - int'(t[i])];
    return o;
  endfunction

  function automatic cd_t pc1(input logic [63:0] key);
    cd_t o;
    for (int i = 0; i < 56; i++) o[55-i] = key[64 - int'(TblPc1[i])];
    return o;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t o;
    for (int i = 0; i < 48; i++) o[47-i] = cd[56 - int'(TblPc2[i])];
    return o;
  endfunction

  // Rotate both 28-bit halves left by one or two.
  function automatic cd_t rot_left(input cd_t cd, input logic [1:0] s);
    cd_t o;
    if (s == 2'd2) o = {cd[53:28], cd[55:54], cd[25:0], cd[27:26]};
    else           o = {cd[54:28], cd[55], cd[26:0], cd[27]};
    return o;
  endfunction

  // Rotate both halves right, undoing rot_left.
  function automatic cd_t rot_right(input cd_t cd, input logic [1:0] s);
    cd_t o;
    if (s == 2'd2) o = {cd[29:28], cd[55:30], cd[1:0], cd[27:2]};
    else           o = {cd[28], cd[55:29], cd[0], cd[27:1]};
    return o;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    logic [31:0] o;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TblE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47 - 6*i -: 6];
      s[31 - 4*i -: 4] = TblS[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32 - int'(TblP[i])];
    return o;
  endfunction

endpackage

/* design/triple_des_block_cipher_core.sv */
// Three-key Triple DES (EDE3) core, 48-stage round pipeline.
// Depends on tdes_pkg for the DES tables and round functions.
// The done strobe follows the start transfer through the 48 round stages (one round a stage).
// Throughput: one block per cycle; busy is held low, since each round has its own stage.
// Subkeys are made on the fly by shift registers traveling beside the data.
// Reset (rst, synchronous) clears the keys, the direction and all stage valid bits.
module triple_des_block_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NS = tdes_pkg::NumStages;

  logic [63:0] key_one, key_two, key_three;
  logic        direction;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_one   <= '0;
      key_two   <= '0;
      key_three <= '0;
      direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tdes_pkg::RegKeyOne:   key_one   <= cfg_data;
        tdes_pkg::RegKeyTwo:   key_two   <= cfg_data;
        tdes_pkg::RegKeyThree: key_three <= cfg_data;
        tdes_pkg::RegDir:      direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Per-stage pipeline state: halves, key schedules for the three passes, direction, valid.
  logic                vld  [NS+1];
  logic                dirp [NS+1];
  logic [31:0]         lh   [NS+1];
  logic [31:0]         rh   [NS+1];
  tdes_pkg::cd_t       cd   [NS+1][3];

  logic [63:0] ip_in;
  tdes_pkg::cd_t ka, kb, kc;

  // Entry: initial permutation and PC-1 of the keys in pass order.
  always_comb begin
    ip_in = tdes_pkg::perm64(block_in, tdes_pkg::TblIp);
    ka = tdes_pkg::pc1(direction ? key_three : key_one);
    kb = tdes_pkg::pc1(key_two);
    kc = tdes_pkg::pc1(direction ? key_one : key_three);
  end

  assign vld[0]   = start && !busy;
  assign dirp[0]  = direction;
  assign lh[0]    = ip_in[63:32];
  assign rh[0]    = ip_in[31:0];
  assign cd[0][0] = ka;
  assign cd[0][1] = kb;
  assign cd[0][2] = kc;

  // One Feistel round a stage.
  for (genvar g = 0; g < NS; g++) begin : g_round
    localparam int Pass = g / tdes_pkg::NumRounds;
    localparam int Rnd  = g % tdes_pkg::NumRounds;
    logic          dec;
    tdes_pkg::cd_t cd_use, cd_keep;
    logic [31:0]   l_in, r_in, f;

    // Pass one and three decrypt when direction is set; pass two the opposite.
    assign dec = (Pass == 1) ? !dirp[g] : dirp[g];

    always_comb begin
      l_in = lh[g];
      r_in = rh[g];
      // Between passes: undo the swap, FP then IP cancel.
      if (Rnd == 0 && Pass != 0) begin
        l_in = rh[g];
        r_in = lh[g];
      end
      // Encrypt rotates before use; decrypt uses the state, then rotates right.
      if (dec) begin
        cd_use  = cd[g][Pass];
        cd_keep = tdes_pkg::rot_right(cd[g][Pass],
                    tdes_pkg::TblRot[tdes_pkg::NumRounds - 1 - Rnd]);
      end else begin
        cd_use  = tdes_pkg::rot_left(cd[g][Pass], tdes_pkg::TblRot[Rnd]);
        cd_keep = cd_use;
      end
      f = tdes_pkg::feistel(r_in, tdes_pkg::pc2(cd_use));
    end

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else     vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      dirp[g+1] <= dirp[g];
      lh[g+1]   <= r_in;
      rh[g+1]   <= l_in ^ f;
      for (int p = 0; p < 3; p++) cd[g+1][p] <= (p == Pass) ? cd_keep : cd[g][p];
    end
  end

  // Output: final swap and permutation.
  assign done      = vld[NS];
  assign block_out = tdes_pkg::perm64({rh[NS], lh[NS]}, tdes_pkg::TblFp);

  // Each done strobe must match a start transfer that entered the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, NS)) else $error("done without matching start");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> $past(start)) else $error("first stage valid without start");
  a_ready: assert property (@(posedge clk) !busy && cfg_ready)
    else $error("core stalled");

endmodule

/* verif/tdes_checker.sv */
// Checker for the Triple DES core: watches the start and done channels, predicts
// each output block with its own DES model and compares. Depends on tdes_pkg.
module tdes_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] block_in,
  input  logic        done,
  input  logic [63:0] block_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Standard DES tables, kept separately from the design's package.
  localparam byte unsigned IP_T [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned FP_T [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned E_T [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam byte unsigned P_T [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam byte unsigned PC1_T [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam byte unsigned PC2_T [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam byte unsigned SHIFT_T [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam byte unsigned SBOX_T [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  logic [63:0] key_a, key_b, key_c;
  logic        decrypt_mode;
  logic [63:0] expected_blocks [$];

  // Bit (p-1) counted from the MSB of a w-bit value.
  function automatic logic pick(input logic [63:0] v, input int w, input int p);
    return v[w - p];
  endfunction

  function automatic logic [63:0] des_block(input logic [63:0] blk, input logic [63:0] key,
                                            input logic inverse);
    logic [47:0] round_keys [16];
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [63:0] v;
    logic [31:0] l, r, t, s, f;
    logic [47:0] x;
    logic [5:0]  b;
    for (int i = 0; i < 56; i++) cd[55-i] = pick(key, 64, PC1_T[i]);
    c = cd[55:28];
    d = cd[27:0];
    for (int k = 0; k < 16; k++) begin
      repeat (SHIFT_T[k]) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      for (int i = 0; i < 48; i++) round_keys[k][47-i] = pick({8'd0, c, d}, 56, PC2_T[i]);
    end
    for (int i = 0; i < 64; i++) v[63-i] = pick(blk, 64, IP_T[i]);
    l = v[63:32];
    r = v[31:0];
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 48; i++) x[47-i] = pick({32'd0, r}, 32, E_T[i]);
      x = x ^ round_keys[inverse ? 15 - k : k];
      for (int i = 0; i < 8; i++) begin
        b = x[47 - 6*i -: 6];
        s[31 - 4*i -: 4] = SBOX_T[i][{b[5], b[0]} * 16 + b[4:1]];
      end
      for (int i = 0; i < 32; i++) f[31-i] = pick({32'd0, s}, 32, P_T[i]);
      t = r;
      r = l ^ f;
      l = t;
    end
    for (int i = 0; i < 64; i++) v[63-i] = pick({r, l}, 64, FP_T[i]);
    return v;
  endfunction

  function automatic logic [63:0] ede3_block(input logic [63:0] blk);
    logic [63:0] b;
    if (decrypt_mode) begin
      b = des_block(blk, key_c, 1'b1);
      b = des_block(b, key_b, 1'b0);
      b = des_block(b, key_a, 1'b1);
    end else begin
      b = des_block(blk, key_a, 1'b0);
      b = des_block(b, key_b, 1'b1);
      b = des_block(b, key_c, 1'b0);
    end
    return b;
  endfunction

  assign pending = expected_blocks.size();

  // Track register writes, queue predictions and check each output transfer.
  always @(posedge clk) begin
    if (rst) begin
      key_a <= '0;
      key_b <= '0;
      key_c <= '0;
      decrypt_mode <= 1'b0;
      fail_count <= 0;
      expected_blocks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdes_pkg::RegKeyOne:   key_a <= cfg_data;
          tdes_pkg::RegKeyTwo:   key_b <= cfg_data;
          tdes_pkg::RegKeyThree: key_c <= cfg_data;
          tdes_pkg::RegDir:      decrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) expected_blocks.push_back(ede3_block(block_in));
      if (done) begin
        if (expected_blocks.size() == 0) begin
          $error("block_out with no block pending: actual %h", block_out);
          fail_count <= fail_count + 1;
        end else begin
          if (block_out !== expected_blocks[0]) begin
            $error("block_out mismatch: expected %h actual %h", expected_blocks[0], block_out);
            fail_count <= fail_count + 1;
          end
          void'(expected_blocks.pop_front());
        end
      end
    end
  end
endmodule

/* verif/tb.sv */
// Testbench top for the Triple DES core: drives keys, direction and blocks with
// random gaps and gives the verdict. Depends on tdes_pkg, tdes_checker and the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 48;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] block_in = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = tdes_pkg::RegKeyOne;
  logic [63:0] cfg_data = '0;
  logic        busy, done, cfg_ready;
  logic [63:0] block_out;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  triple_des_block_cipher_core u_top (.*);

  tdes_checker u_checker (.*);

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One register write transfer, after which valid goes low again on the channel.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_keys(input logic [63:0] k1, input logic [63:0] k2,
                          input logic [63:0] k3, input logic [63:0] dir);
    write_reg(tdes_pkg::RegKeyOne, k1);
    write_reg(tdes_pkg::RegKeyTwo, k2);
    write_reg(tdes_pkg::RegKeyThree, k3);
    write_reg(tdes_pkg::RegDir, dir);
  endtask

  // One block transfer, optionally preceded by random idle cycles. Start stays
  // high afterwards so that blocks can follow back to back.
  task automatic send_block(input logic [63:0] value);
    while (!no_gaps && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    block_in <= value;
    do @(posedge clk); while (busy);
  endtask

  // Let every queued block come out, then let the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Directed blocks, then random phases.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset keys are all zero, a weak key.
    send_block('0);
    send_block('1);
    drain();
    set_keys(64'h0123456789ABCDEF, 64'h23456789ABCDEF01, 64'h456789ABCDEF0123, 64'd0);
    send_block(64'h5468652071756663);
    send_block(64'h8000000000000000);
    send_block(64'h0000000000000001);
    drain();
    // Same keys with the parity bits of key one flipped; encrypt with a wide direction
    // value whose low bit is clear.
    set_keys(64'h0123456789ABCDEF ^ 64'h0101010101010101, 64'h23456789ABCDEF01,
             64'h456789ABCDEF0123, 64'hFFFFFFFFFFFFFFFE);
    send_block(64'h5468652071756663);
    drain();
    write_reg(tdes_pkg::RegDir, 64'hFFFFFFFFFFFFFFFF);
    send_block(64'hA5A5A5A5A5A5A5A5);
    send_block('1);
    drain();
    // Extreme and weak or semi-weak keys.
    set_keys('1, '0, 64'h01FE01FE01FE01FE, 64'd0);
    send_block('0);
    send_block('1);
    drain();
    set_keys(64'hFEFEFEFEFEFEFEFE, 64'h1F1F1F1F0E0E0E0E, '1, 64'd1);
    send_block(64'h0123456789ABCDEF);
    send_block('0);
    drain();
    // Random phases with new settings each time; the fourth runs without gaps.
    for (int phase = 0; phase < 10; phase++) begin
      set_keys(rand64(), rand64(), rand64(), {63'd0, 1'($urandom_range(1))});
      no_gaps = (phase == 3);
      for (int n = 0; n < 125; n++) begin
        send_block(rand64());
        // Hold off once, in the sixth phase, until the pipeline is empty.
        if (n == 60 && phase == 5) begin
          start <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
